// File: rtl/core/brf_pkg.sv
// Package: item types, command codes and fixed widths for the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

	localparam int CAP_W  = 9;
	localparam int QDEPTH = 2;

	// mode codes on the input channel
	localparam logic [2:0] MODE_PUSH    = 3'd0;
	localparam logic [2:0] MODE_POP     = 3'd1;
	localparam logic [2:0] MODE_PEEK    = 3'd2;
	localparam logic [2:0] MODE_DISCARD = 3'd3;
	localparam logic [2:0] MODE_ROOM    = 3'd4;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_PEEK,
		OP_DISCARD,
		OP_ROOM,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic [7:0] count;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       room_ok;
		logic [7:0] fill_level;
	} out_item_t;

	// decoded command passed from front to back; amt is reduced below capacity
	// for peek and discard, raw count for a room query
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [7:0] amt;
	} brf_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/brf_front.sv
// Front end: accepts items, decodes the mode and reduces offsets modulo capacity.
`timescale 1ns / 1ps
`default_nettype none
module brf_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  brf_pkg::in_item_t        in_item,
	input  wire  [brf_pkg::CAP_W-1:0] cap,
	output logic                     cmd_valid,
	input  wire                      cmd_ready,
	output brf_pkg::brf_cmd_t        cmd
);
	import brf_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_SEND = 3'b100
	} fstate_t;

	fstate_t        st_q;
	brf_cmd_t       cmd_q;
	logic [CAP_W-1:0] rem_q;
	logic [7:0]     sh_q;
	logic [2:0]     step_q;

	op_t            op_dec;
	logic [9:0]     trial;
	logic [9:0]     nrem;
	logic           need_div;

	always_comb begin
		unique case (in_item.mode)
			MODE_PUSH:    op_dec = OP_PUSH;
			MODE_POP:     op_dec = OP_POP;
			MODE_PEEK:    op_dec = OP_PEEK;
			MODE_DISCARD: op_dec = OP_DISCARD;
			MODE_ROOM:    op_dec = OP_ROOM;
			default:      op_dec = OP_NOP;
		endcase
	end

	assign need_div = ((op_dec == OP_PEEK) || (op_dec == OP_DISCARD)) &&
		({1'b0, in_item.count} >= cap);

	// one restoring step per cycle, MSB of the count first
	always_comb begin
		trial = {rem_q, sh_q[7]};
		if (trial >= {1'b0, cap}) begin
			nrem = trial - {1'b0, cap};
		end else begin
			nrem = trial;
		end
	end

	assign in_ready  = (st_q == F_IDLE);
	assign cmd_valid = (st_q == F_SEND);
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						st_q <= need_div ? F_DIV : F_SEND;
					end
				end
				F_DIV: begin
					if (step_q == 3'd7) begin
						st_q <= F_SEND;
					end
				end
				F_SEND: begin
					if (cmd_ready) begin
						st_q <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && in_valid) begin
			cmd_q.op   <= op_dec;
			cmd_q.data <= in_item.data_byte;
			cmd_q.amt  <= in_item.count;
			rem_q      <= '0;
			sh_q       <= in_item.count;
			step_q     <= '0;
		end else if (st_q == F_DIV) begin
			rem_q  <= nrem[CAP_W-1:0];
			sh_q   <= {sh_q[6:0], 1'b0};
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				// remainder is below both the count and the capacity
				cmd_q.amt <= nrem[7:0];
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/brf_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module brf_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	output logic               push_ready,
	input  brf_pkg::brf_cmd_t  push_cmd,
	output logic               pop_valid,
	input  wire                pop_ready,
	output brf_pkg::brf_cmd_t  pop_cmd
);
	import brf_pkg::*;

	brf_cmd_t   ent_q [QDEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'(QDEPTH));
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/brf_back.sv
// Back end: ring memory, indices, capacity register and the result register.
`timescale 1ns / 1ps
`default_nettype none
module brf_back #(
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [brf_pkg::CAP_W-1:0] cfg_wdata,
	output logic [brf_pkg::CAP_W-1:0] cap,
	input  wire                       cmd_valid,
	output logic                      cmd_ready,
	input  brf_pkg::brf_cmd_t         cmd,
	output logic                      out_valid,
	input  wire                       out_ready,
	output brf_pkg::out_item_t        out_item
);
	import brf_pkg::*;

	localparam int CAP_MAX = (DEPTH < 511) ? DEPTH : 511;
	localparam int CAP_RST = (CAP_MAX < 256) ? CAP_MAX : 256;
	localparam int AW      = $clog2(CAP_MAX);

	logic [7:0]       mem [CAP_MAX];
	logic [CAP_W-1:0] cap_q;
	logic [AW-1:0]    w_q;
	logic [AW-1:0]    r_q;
	logic [7:0]       rd_q;

	logic             s2_v_q;
	logic             rdflag_s2;
	logic             room_s2;
	logic [7:0]       amt_s2;

	logic             out_v_q;
	out_item_t        out_q;

	logic             take;
	logic [AW-1:0]    peek_addr;
	logic [AW-1:0]    rd_addr;
	logic [CAP_W-1:0] cap_sat;
	logic [9:0]       fill;
	logic [10:0]      room_sum;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
			input logic [7:0] b, input logic [CAP_W-1:0] c);
		logic [9:0] s;
		s = 10'(a) + 10'(b);
		if (s >= 10'(c)) begin
			s = s - 10'(c);
		end
		return s[AW-1:0];
	endfunction

	// one item in flight: s2 must be empty and the result register free next cycle
	assign take      = cmd_valid && !s2_v_q && (!out_v_q || out_ready);
	assign cmd_ready = !s2_v_q && (!out_v_q || out_ready);
	assign cap       = cap_q;
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	assign peek_addr = wrap_add(r_q, cmd.amt, cap_q);
	assign rd_addr   = (cmd.op == OP_PEEK) ? peek_addr : r_q;

	always_comb begin
		if (cfg_wdata < 9'd2) begin
			cap_sat = 9'd2;
		end else if (10'(cfg_wdata) > 10'(CAP_MAX)) begin
			cap_sat = CAP_W'(CAP_MAX);
		end else begin
			cap_sat = cfg_wdata;
		end
	end

	// fill level from the indices as they stand after the item
	always_comb begin
		if (w_q >= r_q) begin
			fill = 10'(w_q) - 10'(r_q);
		end else begin
			fill = 10'(w_q) + 10'(cap_q) - 10'(r_q);
		end
		room_sum = 11'(fill) + 11'(amt_s2) + 11'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_W'(CAP_RST);
			w_q     <= '0;
			r_q     <= '0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cap_sat;
				w_q   <= '0;
				r_q   <= '0;
			end else if (take) begin
				case (cmd.op)
					OP_PUSH:    w_q <= wrap_add(w_q, 8'd1, cap_q);
					OP_POP:     r_q <= wrap_add(r_q, 8'd1, cap_q);
					OP_DISCARD: r_q <= peek_addr;
					default:    ;
				endcase
			end
			s2_v_q <= take;
			if (s2_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (cmd.op) inside
				OP_POP, OP_PEEK: rdflag_s2 <= 1'b1;
				default:         rdflag_s2 <= 1'b0;
			endcase
			room_s2 <= (cmd.op == OP_ROOM);
			amt_s2  <= cmd.amt;
		end
		if (s2_v_q) begin
			out_q.read_data  <= rdflag_s2 ? rd_q : 8'd0;
			out_q.room_ok    <= room_s2 && (room_sum <= 11'(cap_q));
			out_q.fill_level <= fill[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take && (cmd.op == OP_PUSH)) begin
			mem[w_q] <= cmd.data;
		end
		if (take) begin
			rd_q <= mem[rd_addr];
		end
	end

	a_widx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		10'(w_q) < 10'(cap_q))
		else $error("write index outside capacity");

	a_ridx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		10'(r_q) < 10'(cap_q))
		else $error("read index outside capacity");

	a_s2_drains: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |=> out_v_q)
		else $error("s2 item not moved into result register");

	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> !take)
		else $error("command taken while another is in s2");

	a_fill_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> (fill < 10'(cap_q)))
		else $error("fill level not below capacity");

endmodule
`default_nettype wire

// File: rtl/core/byte_ring_fifo_core.sv
// Byte ring FIFO: item front end, command queue and ring back end.
//
// Each input item is one operation (push, pop, peek, discard, room query);
// each yields exactly one result item carrying read data, the room flag and
// the fill level after the operation. Both channels are valid/ready.
// cfg_we/cfg_wdata set the ring size in use (clamped to 2..min(DEPTH,511))
// and empty the ring; write it only while no item is outstanding.
// An item passes the front end's command register and the queue, then the
// back end's memory read and s2 stage into the result register; a peek or
// discard with a count not below the capacity first runs through the front-end
// modulo unit (one remainder bit per cycle). Front (accept/send handshake)
// and back (registered memory read ahead of the result register) each take a
// new item only once the last has moved on; the 2-entry queue lets the front
// accept while the back stalls. Reset clears the indices, sets the capacity to
// min(256,DEPTH) and empties the queue; memory contents are undefined until
// written. When the receiver stalls, the result holds, the queue fills, and then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_fifo_core #(
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [brf_pkg::CAP_W-1:0] cfg_wdata,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  brf_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  wire                       out_ready,
	output brf_pkg::out_item_t        out_item
);
	import brf_pkg::*;

	logic [CAP_W-1:0] cap;
	logic             f_valid;
	logic             f_ready;
	brf_cmd_t         f_cmd;
	logic             b_valid;
	logic             b_ready;
	brf_cmd_t         b_cmd;

	brf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cap       (cap),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	brf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	brf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cap       (cap),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire
